>>> src/bpis_pkg.sv
// Shared types and constants for the BSP point-in-sector core.
package bpis_pkg;

    localparam int NODES_DEFAULT      = 4096;
    localparam int SUBSECTORS_DEFAULT = 4096;

    localparam logic [1:0] ACT_LOAD_NODE   = 2'd0;
    localparam logic [1:0] ACT_LOAD_SECTOR = 2'd1;
    localparam logic [1:0] ACT_QUERY       = 2'd2;

    localparam int LEAF_BIT = 15;

    typedef struct packed {
        logic [15:0] dy;
        logic [15:0] dx;
        logic [15:0] y;
        logic [15:0] x;
    } part_t;

    typedef struct packed {
        logic [15:0] back;
        logic [15:0] front;
    } child_t;

    typedef struct packed {
        child_t child;
        part_t  part;
    } node_t;

    typedef struct packed {
        logic done;
        logic side;
    } side_rsp_t;

endpackage

>>> src/bpis_tables.sv
// Node table and subsector-to-sector table, one write and one registered read port each.
module bpis_tables import bpis_pkg::*; #(
    parameter int NODES      = NODES_DEFAULT,
    parameter int SUBSECTORS = SUBSECTORS_DEFAULT,
    localparam int NAW = (NODES > 1) ? $clog2(NODES) : 1,
    localparam int SAW = (SUBSECTORS > 1) ? $clog2(SUBSECTORS) : 1
) (
    input  logic           aclk,
    input  logic           node_wr_en,
    input  logic [NAW-1:0] node_wr_addr,
    input  node_t          node_wr_data,
    input  logic           node_rd_en,
    input  logic [NAW-1:0] node_rd_addr,
    output node_t          node_rd_data,
    input  logic           sect_wr_en,
    input  logic [SAW-1:0] sect_wr_addr,
    input  logic [15:0]    sect_wr_data,
    input  logic           sect_rd_en,
    input  logic [SAW-1:0] sect_rd_addr,
    output logic [15:0]    sect_rd_data
);

    node_t       node_mem [NODES];
    logic [15:0] sect_mem [SUBSECTORS];
    node_t       node_rd_reg;
    logic [15:0] sect_rd_reg;

    always_ff @(posedge aclk) begin
        if (node_wr_en) begin
            node_mem[node_wr_addr] <= node_wr_data;
        end
        if (node_rd_en) begin
            node_rd_reg <= node_mem[node_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (sect_wr_en) begin
            sect_mem[sect_wr_addr] <= sect_wr_data;
        end
        if (sect_rd_en) begin
            sect_rd_reg <= sect_mem[sect_rd_addr];
        end
    end

    assign node_rd_data = node_rd_reg;
    assign sect_rd_data = sect_rd_reg;

endmodule

>>> src/bpis_side.sv
// Partition side test with one shared 16x32 multiplier, used twice per node when the quick test cannot decide.
module bpis_side import bpis_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] px,
    input  logic [31:0] py,
    input  part_t       part,
    output side_rsp_t   rsp
);

    typedef enum logic [1:0] {S_IDLE, S_MUL_A, S_MUL_B, S_CMP} state_t;

    state_t      state_reg;
    logic        done_reg;
    logic        side_reg;
    logic [15:0] ndx_reg;
    logic [15:0] ndy_reg;
    logic [31:0] dx_reg;
    logic [31:0] dy_reg;
    logic [31:0] left_reg;
    logic [31:0] right_reg;

    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] dx;
    logic [31:0] dy;
    logic        quick;
    logic        quick_side;
    logic [15:0] mul_a;
    logic [31:0] mul_b;
    logic [47:0] prod;

    assign fx = {part.x, 16'h0000};
    assign fy = {part.y, 16'h0000};
    assign dx = px - fx;
    assign dy = py - fy;

    always_comb begin
        quick      = 1'b1;
        quick_side = 1'b0;
        if (part.dx == 16'h0000) begin
            quick_side = ($signed(px) <= $signed(fx)) ? (!part.dy[15] && part.dy != 16'h0000)
                                                       : part.dy[15];
        end else if (part.dy == 16'h0000) begin
            quick_side = ($signed(py) <= $signed(fy)) ? part.dx[15]
                                                       : (!part.dx[15] && part.dx != 16'h0000);
        end else if (part.dy[15] ^ part.dx[15] ^ dx[31] ^ dy[31]) begin
            quick_side = part.dy[15] ^ dx[31];
        end else begin
            quick = 1'b0;
        end
    end

    assign mul_a = (state_reg == S_MUL_A) ? ndy_reg : ndx_reg;
    assign mul_b = (state_reg == S_MUL_A) ? dx_reg : dy_reg;
    assign prod  = {{32{mul_a[15]}}, mul_a} * {{16{mul_b[31]}}, mul_b};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    done_reg <= start && quick;
                    if (start) begin
                        if (quick) begin
                            side_reg <= quick_side;
                        end else begin
                            ndx_reg   <= part.dx;
                            ndy_reg   <= part.dy;
                            dx_reg    <= dx;
                            dy_reg    <= dy;
                            state_reg <= S_MUL_A;
                        end
                    end
                end
                S_MUL_A: begin
                    done_reg  <= 1'b0;
                    left_reg  <= prod[47:16];
                    state_reg <= S_MUL_B;
                end
                S_MUL_B: begin
                    done_reg  <= 1'b0;
                    right_reg <= prod[47:16];
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    side_reg  <= !($signed(right_reg) < $signed(left_reg));
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp = {done_reg, side_reg};

`ifndef SYNTHESIS
    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == S_IDLE)
        else $error("side test started while busy");

    a_cmp_gives_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CMP |=> done_reg && state_reg == S_IDLE)
        else $error("compare step did not complete");
`endif

endmodule

>>> src/bsp_point_in_sector_core.sv
// Top level: BSP walk sequencer, config register and output register.
//
//  channel | direction | signals                         | handshake
//  s_      | in        | s_action .. s_point_y           | s_valid / s_ready
//  m_      | out       | m_sector, m_subsector           | m_valid / m_ready
//  cfg_    | in        | cfg_data (node_count)           | cfg_valid / cfg_ready
//
// Loads and unknown actions finish when accepted. A query does a leaf check, a sector read
// and the output (no leaf check with node_count 0), plus a node read and a side test per node,
// the side test either quick or running the shared multiplier twice; tree depth sets the total.
// Reset clears node_count and control; tables are not cleared.
// s_ready is low while a query walks; a finished query holds while the output register is full.
module bsp_point_in_sector_core import bpis_pkg::*; #(
    parameter int NODES      = NODES_DEFAULT,
    parameter int SUBSECTORS = SUBSECTORS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [11:0] s_entry_index,
    input  logic [15:0] s_part_x,
    input  logic [15:0] s_part_y,
    input  logic [15:0] s_part_dx,
    input  logic [15:0] s_part_dy,
    input  logic [15:0] s_child_front,
    input  logic [15:0] s_child_back,
    input  logic [15:0] s_sector_value,
    input  logic [31:0] s_point_x,
    input  logic [31:0] s_point_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_sector,
    output logic [14:0] m_subsector
);

    localparam int NAW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SAW = (SUBSECTORS > 1) ? $clog2(SUBSECTORS) : 1;
    localparam int STW = $clog2(NODES + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_NODE_WAIT, ST_SIDE, ST_SECT, ST_FINISH
    } state_t;

    state_t         state_reg;
    logic [12:0]    node_count_reg;
    logic [15:0]    n_reg;
    logic [STW-1:0] steps_reg;
    logic [14:0]    ss_reg;
    logic           ss_ok_reg;
    logic [31:0]    px_reg;
    logic [31:0]    py_reg;
    logic           m_valid_reg;
    logic [15:0]    m_sector_reg;
    logic [14:0]    m_subsector_reg;

    logic           accept;
    logic [16:0]    entry_ext;
    logic           node_wr_en;
    logic           sect_wr_en;
    node_t          node_wr_data;
    logic           node_rd_en;
    node_t          node_rd_data;
    logic           sect_rd_en;
    logic [15:0]    sect_rd_data;
    logic           ss_in_range;
    logic           n_out_of_range;
    logic           side_start;
    side_rsp_t      side_rsp;
    logic           out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign entry_ext = {5'b0, s_entry_index};

    assign node_wr_en = accept && s_action == ACT_LOAD_NODE && entry_ext < 17'(NODES);
    assign sect_wr_en = accept && s_action == ACT_LOAD_SECTOR && entry_ext < 17'(SUBSECTORS);
    assign node_wr_data = {s_child_back, s_child_front,
                           s_part_dy, s_part_dx, s_part_y, s_part_x};

    assign n_out_of_range = ({1'b0, n_reg} >= 17'(NODES)) || (steps_reg >= STW'(NODES));
    assign node_rd_en     = (state_reg == ST_CHECK) && !n_reg[LEAF_BIT] && !n_out_of_range;
    assign ss_in_range    = {2'b0, ss_reg} < 17'(SUBSECTORS);
    assign sect_rd_en     = (state_reg == ST_SECT) && ss_in_range;
    assign side_start     = (state_reg == ST_NODE_WAIT);
    assign out_free       = !m_valid_reg || m_ready;

    bpis_tables #(
        .NODES      (NODES),
        .SUBSECTORS (SUBSECTORS)
    ) u_tables (
        .aclk         (aclk),
        .node_wr_en   (node_wr_en),
        .node_wr_addr (entry_ext[NAW-1:0]),
        .node_wr_data (node_wr_data),
        .node_rd_en   (node_rd_en),
        .node_rd_addr (n_reg[NAW-1:0]),
        .node_rd_data (node_rd_data),
        .sect_wr_en   (sect_wr_en),
        .sect_wr_addr (entry_ext[SAW-1:0]),
        .sect_wr_data (s_sector_value),
        .sect_rd_en   (sect_rd_en),
        .sect_rd_addr (ss_reg[SAW-1:0]),
        .sect_rd_data (sect_rd_data)
    );

    bpis_side u_side (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (side_start),
        .px      (px_reg),
        .py      (py_reg),
        .part    (node_rd_data.part),
        .rsp     (side_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= 13'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                node_count_reg <= cfg_data;
            end
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && s_action == ACT_QUERY) begin
                        px_reg    <= s_point_x;
                        py_reg    <= s_point_y;
                        steps_reg <= '0;
                        if (node_count_reg == 13'd0) begin
                            ss_reg    <= 15'd0;
                            state_reg <= ST_SECT;
                        end else begin
                            n_reg     <= {3'b0, node_count_reg - 13'd1};
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    if (n_reg[LEAF_BIT]) begin
                        ss_reg    <= n_reg[14:0];
                        state_reg <= ST_SECT;
                    end else if (n_out_of_range) begin
                        ss_reg    <= 15'd0;
                        state_reg <= ST_SECT;
                    end else begin
                        state_reg <= ST_NODE_WAIT;
                    end
                end
                ST_NODE_WAIT: begin
                    state_reg <= ST_SIDE;
                end
                ST_SIDE: begin
                    if (side_rsp.done) begin
                        n_reg     <= side_rsp.side ? node_rd_data.child.back
                                                   : node_rd_data.child.front;
                        steps_reg <= steps_reg + STW'(1);
                        state_reg <= ST_CHECK;
                    end
                end
                ST_SECT: begin
                    ss_ok_reg <= ss_in_range;
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_sector_reg    <= ss_ok_reg ? sect_rd_data : 16'h0000;
                        m_subsector_reg <= ss_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_sector    = m_sector_reg;
    assign m_subsector = m_subsector_reg;

`ifndef SYNTHESIS
    a_steps_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE && state_reg != ST_SECT && state_reg != ST_FINISH
        |-> steps_reg <= STW'(NODES))
        else $error("walk step count beyond table size");

    a_node_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        node_rd_en |-> {1'b0, n_reg} < 17'(NODES))
        else $error("node read outside table");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_action == ACT_QUERY |=> !s_ready)
        else $error("ready during query walk");
`endif

endmodule
